[hdl/mbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, formats and codes for the escape-time iteration block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // input fixed-point format and internal z format (Q20.43)
    localparam int FRAC_BITS = 60;
    localparam int Z_FRAC    = 43;
    localparam int Z_W       = 64;
    localparam int Z_SHR     = (FRAC_BITS >= Z_FRAC) ? (FRAC_BITS - Z_FRAC) : 0;
    localparam int Z_SHL     = (FRAC_BITS < Z_FRAC) ? (Z_FRAC - FRAC_BITS) : 0;

    // register widths
    localparam int ITER_W  = 16;
    localparam int COLOR_W = 13;
    localparam int ESC_W   = 18;

    // width of a clamped square (escape_limit * 2^43)
    localparam int MAG_W   = ESC_W + Z_FRAC;
    // full product of two 64 bit magnitudes
    localparam int PROD_W  = 2 * Z_W;
    localparam int HALF_W  = Z_W / 2;

    // configuration port
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes
    localparam logic [1:0] REG_MAX_ITER = 2'd0;
    localparam logic [1:0] REG_COLOR    = 2'd1;
    localparam logic [1:0] REG_ESCAPE   = 2'd2;

    // register reset values
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd1000;
    localparam logic [COLOR_W-1:0] COLOR_RST    = 13'd256;
    localparam logic [ESC_W-1:0]   ESCAPE_RST   = 18'd250000;

    // saturation bounds of the z format
    localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

    typedef struct packed {
        logic signed [Z_W-1:0] c_real;
        logic signed [Z_W-1:0] c_imag;
    } in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] level;
        logic               in_set;
    } out_t;

    typedef struct packed {
        logic [ITER_W-1:0]  max_iterations;
        logic [COLOR_W-1:0] color_count;
        logic [ESC_W-1:0]   escape_limit;
    } cfg_t;

    // multiplier operand select
    typedef enum logic [1:0] {
        OP_NONE,
        OP_XY,
        OP_XX,
        OP_YY
    } op_sel_t;

    // product shift and capture select
    typedef enum logic [1:0] {
        SH_NONE,
        SH_XY,
        SH_XX,
        SH_YY
    } sh_sel_t;

    typedef struct packed {
        logic    load;
        logic    check;
        op_sel_t op_sel;
        logic    upd_x;
        sh_sel_t sh_sel;
        logic    upd_y;
        logic    step;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic cont;
    } sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_OP_XY,
        ST_OP_XX,
        ST_MUL_XX,
        ST_SHIFT_XY,
        ST_UPD_Y,
        ST_OP_YY,
        ST_MUL_YY,
        ST_PROD_YY,
        ST_SHIFT_YY,
        ST_FINISH
    } state_t;

endpackage

[hdl/mbe_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_regs
// Configuration registers behind an APB-style write/read port.
// ----------------------------------------------------------------------------
module mbe_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic [mbe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mbe_pkg::cfg_t               cfg
);

    mbe_pkg::cfg_t cfg_reg;
    mbe_pkg::cfg_t cfg_next;
    logic [1:0]    index;
    logic          wr_en;

    assign index  = paddr[3:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                mbe_pkg::REG_MAX_ITER:
                    cfg_next.max_iterations = pwdata[mbe_pkg::ITER_W-1:0];
                mbe_pkg::REG_COLOR:
                    cfg_next.color_count = pwdata[mbe_pkg::COLOR_W-1:0];
                mbe_pkg::REG_ESCAPE:
                    cfg_next.escape_limit = pwdata[mbe_pkg::ESC_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iterations <= mbe_pkg::MAX_ITER_RST;
            cfg_reg.color_count    <= mbe_pkg::COLOR_RST;
            cfg_reg.escape_limit   <= mbe_pkg::ESCAPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (index)
            mbe_pkg::REG_MAX_ITER:
                prdata = {{(mbe_pkg::DATA_W-mbe_pkg::ITER_W){1'b0}}, cfg_reg.max_iterations};
            mbe_pkg::REG_COLOR:
                prdata = {{(mbe_pkg::DATA_W-mbe_pkg::COLOR_W){1'b0}}, cfg_reg.color_count};
            mbe_pkg::REG_ESCAPE:
                prdata = {{(mbe_pkg::DATA_W-mbe_pkg::ESC_W){1'b0}}, cfg_reg.escape_limit};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hdl/mbe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer for one point: schedules the shared multiplier pipeline and the
// z updates of each iteration, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module mbe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  mbe_pkg::sts_t  sts,
    output mbe_pkg::cmd_t  cmd
);

    mbe_pkg::state_t state_reg;
    mbe_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // output slot can take a result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbe_pkg::ST_IDLE:
                if (in_valid)
                    state_next = mbe_pkg::ST_CHECK;
            mbe_pkg::ST_CHECK:
                state_next = sts.cont ? mbe_pkg::ST_OP_XY : mbe_pkg::ST_FINISH;
            mbe_pkg::ST_OP_XY:    state_next = mbe_pkg::ST_OP_XX;
            mbe_pkg::ST_OP_XX:    state_next = mbe_pkg::ST_MUL_XX;
            mbe_pkg::ST_MUL_XX:   state_next = mbe_pkg::ST_SHIFT_XY;
            mbe_pkg::ST_SHIFT_XY: state_next = mbe_pkg::ST_UPD_Y;
            mbe_pkg::ST_UPD_Y:    state_next = mbe_pkg::ST_OP_YY;
            mbe_pkg::ST_OP_YY:    state_next = mbe_pkg::ST_MUL_YY;
            mbe_pkg::ST_MUL_YY:   state_next = mbe_pkg::ST_PROD_YY;
            mbe_pkg::ST_PROD_YY:  state_next = mbe_pkg::ST_SHIFT_YY;
            mbe_pkg::ST_SHIFT_YY: state_next = mbe_pkg::ST_CHECK;
            mbe_pkg::ST_FINISH:
                if (out_free)
                    state_next = mbe_pkg::ST_IDLE;
            default:
                state_next = mbe_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.op_sel   = mbe_pkg::OP_NONE;
        cmd.sh_sel   = mbe_pkg::SH_NONE;
        case (state_reg)
            mbe_pkg::ST_IDLE:
                cmd.load = in_valid;
            mbe_pkg::ST_CHECK:
                cmd.check = 1'b1;
            mbe_pkg::ST_OP_XY:
            begin
                cmd.op_sel = mbe_pkg::OP_XY;
                cmd.upd_x  = 1'b1;
            end
            mbe_pkg::ST_OP_XX:
                cmd.op_sel = mbe_pkg::OP_XX;
            mbe_pkg::ST_SHIFT_XY:
                cmd.sh_sel = mbe_pkg::SH_XY;
            mbe_pkg::ST_UPD_Y:
            begin
                cmd.sh_sel = mbe_pkg::SH_XX;
                cmd.upd_y  = 1'b1;
            end
            mbe_pkg::ST_OP_YY:
                cmd.op_sel = mbe_pkg::OP_YY;
            mbe_pkg::ST_SHIFT_YY:
            begin
                cmd.sh_sel = mbe_pkg::SH_YY;
                cmd.step   = 1'b1;
            end
            mbe_pkg::ST_FINISH:
                cmd.load_out = out_free;
            default:
                cmd = '0;
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != mbe_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hdl/mbe_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_dp
// Iteration datapath: z registers, a four-way 32x32 multiplier pipeline with
// shift and clamp, saturating updates, counters and the result register.
// ----------------------------------------------------------------------------
module mbe_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  mbe_pkg::cfg_t  cfg,
    input  mbe_pkg::in_t   in_data,
    input  mbe_pkg::cmd_t  cmd,
    output mbe_pkg::sts_t  sts,
    output mbe_pkg::out_t  out_data
);

    // z registers and constants of the current point
    logic signed [mbe_pkg::Z_W-1:0]   cr_reg;
    logic signed [mbe_pkg::Z_W-1:0]   ci_reg;
    logic signed [mbe_pkg::Z_W-1:0]   x_reg;
    logic signed [mbe_pkg::Z_W-1:0]   y_reg;
    logic [mbe_pkg::MAG_W-1:0]        x2_reg;
    logic [mbe_pkg::MAG_W-1:0]        y2_reg;
    logic signed [mbe_pkg::MAG_W:0]   diff_reg;
    logic [mbe_pkg::Z_W-2:0]          t_reg;
    logic                             neg_reg;

    // multiplier pipeline
    logic [mbe_pkg::Z_W-1:0]          opa_reg;
    logic [mbe_pkg::Z_W-1:0]          opb_reg;
    logic [mbe_pkg::Z_W-1:0]          p00_reg;
    logic [mbe_pkg::Z_W-1:0]          p01_reg;
    logic [mbe_pkg::Z_W-1:0]          p10_reg;
    logic [mbe_pkg::Z_W-1:0]          p11_reg;
    logic [mbe_pkg::PROD_W-1:0]       prod_reg;

    // counters and result
    logic [mbe_pkg::ITER_W-1:0]       iter_reg;
    logic [mbe_pkg::COLOR_W-1:0]      lvl_reg;
    logic [mbe_pkg::COLOR_W-1:0]      lvl_inc;
    mbe_pkg::out_t                    out_reg;
    mbe_pkg::out_t                    result;

    logic [mbe_pkg::MAG_W-1:0]        cap;
    logic [mbe_pkg::Z_W-1:0]          mag_x;
    logic [mbe_pkg::Z_W-1:0]          mag_y;
    logic [mbe_pkg::Z_W-1:0]          r_xy;
    logic [mbe_pkg::Z_W-1:0]          r_sq;
    logic                             ovf_xy;
    logic                             ovf_sq;
    logic [mbe_pkg::Z_W-2:0]          t_res;
    logic [mbe_pkg::MAG_W-1:0]        sq_res;
    logic [mbe_pkg::MAG_W:0]          mag_sum;
    logic signed [mbe_pkg::Z_W:0]     nx_sum;
    logic signed [mbe_pkg::Z_W:0]     ny_sum;

    // input format to Q20.43
    function automatic logic signed [mbe_pkg::Z_W-1:0] to_z(input logic [mbe_pkg::Z_W-1:0] raw);
        logic signed [mbe_pkg::Z_W-1:0] top;
        begin
            top = $signed(raw) >>> (mbe_pkg::Z_W - 1 - mbe_pkg::Z_SHL);
            if (mbe_pkg::FRAC_BITS >= mbe_pkg::Z_FRAC)
                to_z = $signed(raw) >>> mbe_pkg::Z_SHR;
            else if (top == '0 || top == '1)
                to_z = $signed(raw << mbe_pkg::Z_SHL);
            else
                to_z = raw[mbe_pkg::Z_W-1] ? mbe_pkg::Z_MIN : mbe_pkg::Z_MAX;
        end
    endfunction

    // saturate a one-bit-wider sum to the z range
    function automatic logic signed [mbe_pkg::Z_W-1:0] sat_z(input logic signed [mbe_pkg::Z_W:0] s);
        begin
            if (s[mbe_pkg::Z_W] != s[mbe_pkg::Z_W-1])
                sat_z = s[mbe_pkg::Z_W] ? mbe_pkg::Z_MIN : mbe_pkg::Z_MAX;
            else
                sat_z = s[mbe_pkg::Z_W-1:0];
        end
    endfunction

    assign cap   = {cfg.escape_limit, {mbe_pkg::Z_FRAC{1'b0}}};
    assign mag_x = x_reg[mbe_pkg::Z_W-1] ? (mbe_pkg::Z_W'(0) - x_reg) : x_reg;
    assign mag_y = y_reg[mbe_pkg::Z_W-1] ? (mbe_pkg::Z_W'(0) - y_reg) : y_reg;

    // loop condition
    assign mag_sum  = {1'b0, x2_reg} + {1'b0, y2_reg};
    assign sts.cont = (iter_reg < cfg.max_iterations) && (mag_sum < {1'b0, cap});

    // product shift and clamp: cross term keeps one more fraction bit
    assign r_xy   = prod_reg[mbe_pkg::Z_FRAC-1 +: mbe_pkg::Z_W];
    assign ovf_xy = |prod_reg[mbe_pkg::PROD_W-1:mbe_pkg::Z_FRAC-1+mbe_pkg::Z_W];
    assign r_sq   = prod_reg[mbe_pkg::Z_FRAC +: mbe_pkg::Z_W];
    assign ovf_sq = |prod_reg[mbe_pkg::PROD_W-1:mbe_pkg::Z_FRAC+mbe_pkg::Z_W];
    assign t_res  = (ovf_xy || r_xy >= {1'b0, mbe_pkg::Z_MAX[mbe_pkg::Z_W-2:0]})
                    ? mbe_pkg::Z_MAX[mbe_pkg::Z_W-2:0] : r_xy[mbe_pkg::Z_W-2:0];
    assign sq_res = (ovf_sq || r_sq >= {{(mbe_pkg::Z_W-mbe_pkg::MAG_W){1'b0}}, cap})
                    ? cap : r_sq[mbe_pkg::MAG_W-1:0];

    // saturating updates
    assign nx_sum = {{(mbe_pkg::Z_W-mbe_pkg::MAG_W){diff_reg[mbe_pkg::MAG_W]}}, diff_reg}
                    + {cr_reg[mbe_pkg::Z_W-1], cr_reg};
    assign ny_sum = neg_reg ? ({ci_reg[mbe_pkg::Z_W-1], ci_reg} - {2'b00, t_reg})
                            : ({ci_reg[mbe_pkg::Z_W-1], ci_reg} + {2'b00, t_reg});

    // level counter wraps at color_count
    assign lvl_inc = lvl_reg + mbe_pkg::COLOR_W'(1);

    // z state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            lvl_reg  <= '0;
        end
        else if (cmd.load)
        begin
            iter_reg <= '0;
            lvl_reg  <= '0;
        end
        else if (cmd.step)
        begin
            iter_reg <= iter_reg + mbe_pkg::ITER_W'(1);
            lvl_reg  <= (lvl_inc == cfg.color_count) ? '0 : lvl_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= to_z(in_data.c_real);
            ci_reg <= to_z(in_data.c_imag);
            x_reg  <= '0;
            y_reg  <= '0;
            x2_reg <= '0;
            y2_reg <= '0;
        end
        else
        begin
            if (cmd.upd_x)
                x_reg <= sat_z(nx_sum);
            if (cmd.upd_y)
                y_reg <= sat_z(ny_sum);
            case (cmd.sh_sel)
                mbe_pkg::SH_XY: t_reg  <= t_res;
                mbe_pkg::SH_XX: x2_reg <= sq_res;
                mbe_pkg::SH_YY: y2_reg <= sq_res;
                default:        t_reg  <= t_reg;
            endcase
        end
        if (cmd.check)
            diff_reg <= $signed({1'b0, x2_reg}) - $signed({1'b0, y2_reg});
    end

    // multiplier operands
    always_ff @(posedge clk)
    begin
        case (cmd.op_sel)
            mbe_pkg::OP_XY:
            begin
                opa_reg <= mag_x;
                opb_reg <= mag_y;
                neg_reg <= x_reg[mbe_pkg::Z_W-1] ^ y_reg[mbe_pkg::Z_W-1];
            end
            mbe_pkg::OP_XX:
            begin
                opa_reg <= mag_x;
                opb_reg <= mag_x;
            end
            mbe_pkg::OP_YY:
            begin
                opa_reg <= mag_y;
                opb_reg <= mag_y;
            end
            default:
                opa_reg <= opa_reg;
        endcase
    end

    // partial products, then the full product
    always_ff @(posedge clk)
    begin
        p00_reg  <= opa_reg[mbe_pkg::HALF_W-1:0] * opb_reg[mbe_pkg::HALF_W-1:0];
        p01_reg  <= opa_reg[mbe_pkg::HALF_W-1:0] * opb_reg[mbe_pkg::Z_W-1:mbe_pkg::HALF_W];
        p10_reg  <= opa_reg[mbe_pkg::Z_W-1:mbe_pkg::HALF_W] * opb_reg[mbe_pkg::HALF_W-1:0];
        p11_reg  <= opa_reg[mbe_pkg::Z_W-1:mbe_pkg::HALF_W]
                    * opb_reg[mbe_pkg::Z_W-1:mbe_pkg::HALF_W];
        prod_reg <= {p11_reg, p00_reg}
                    + {{mbe_pkg::HALF_W{1'b0}}, p01_reg, {mbe_pkg::HALF_W{1'b0}}}
                    + {{mbe_pkg::HALF_W{1'b0}}, p10_reg, {mbe_pkg::HALF_W{1'b0}}};
    end

    // result of the finished point
    always_comb
    begin
        result.in_set = (iter_reg == cfg.max_iterations);
        if (result.in_set)
            result.level = cfg.color_count;
        else if (cfg.color_count == '0)
            result.level = '0;
        else
            result.level = lvl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_reg <= result;
    end

    assign out_data = out_reg;

endmodule

[hdl/mandelbrot_escape_time.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time level of one complex point: iterates z = z*z + c in Q20.43
// fixed point until the dwell limit or the escape bound is reached.
// ----------------------------------------------------------------------------
// one point at a time: in_stall stays high until the result is loaded into
//   the output register; each iteration takes three passes through the
//   shared four-way 32x32 multiplier pipeline (xy, x*x, y*y)
// a new point is taken while the previous result waits in the output register
// reset: asynchronous active low; registers return to 1000 / 256 / 250000,
//   the sequencer goes idle and no result is pending
module mandelbrot_escape_time (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mbe_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mbe_pkg::out_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic [mbe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    mbe_pkg::cfg_t cfg;
    mbe_pkg::cmd_t cmd;
    mbe_pkg::sts_t sts;

    // configuration registers
    mbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // iteration datapath
    mbe_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule
